@@ rtl/core/multichannel_biquad_filter_top_defines.svh @@
// assertion macros shared by the biquad filter rtl
`ifndef MULTICHANNEL_BIQUAD_FILTER_TOP_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_FILTER_TOP_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define BQF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bqf check failed");

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define BQF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bqf check failed");

`endif

@@ rtl/core/bqf_pkg.sv @@
// types, constants and microcode rom of the biquad filter
`timescale 1ns / 1ps

package bqf_pkg;

    localparam int CHANNELS_DEF = 16;
    localparam int SAMPLE_W     = 24;
    localparam int CH_W         = 4;
    localparam int COEF_W       = 24;
    localparam int HIST_W       = 32;
    localparam int PROD_W       = COEF_W + HIST_W;
    localparam int ACC_W        = 60;
    localparam int FRAC         = 20;
    localparam int CFG_IDX_W    = 3;
    localparam int STEP_W       = 4;

    localparam logic signed [COEF_W-1:0] FF0_RESET = 24'sd1048576;

    localparam logic [STEP_W-1:0] STEP_WAIT = 4'd0;
    localparam logic [STEP_W-1:0] STEP_OUT  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_LAST = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FF0 = 3'd0,
        REG_FF1 = 3'd1,
        REG_FF2 = 3'd2,
        REG_FB1 = 3'd3,
        REG_FB2 = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ACC_HOLD      = 3'd0,
        ACC_LOAD_X    = 3'd1,
        ACC_LOAD_PROD = 3'd2,
        ACC_SUB       = 3'd3,
        ACC_ADD       = 3'd4
    } t_acc_op;

    typedef enum logic [2:0] {
        MUL_NONE = 3'd0,
        MUL_B1H1 = 3'd1,
        MUL_B2H2 = 3'd2,
        MUL_A1H1 = 3'd3,
        MUL_A2H2 = 3'd4,
        MUL_A0W  = 3'd5
    } t_mul_sel;

    typedef enum logic [1:0] {
        JMP_NONE     = 2'd0,
        JMP_NO_INPUT = 2'd1,
        JMP_BAD_CH   = 2'd2,
        JMP_OUT_BUSY = 2'd3
    } t_jmp;

    typedef struct packed {
        logic              in_ready;
        t_acc_op           acc_op;
        t_mul_sel          mul_sel;
        logic              load_w;
        logic              mem_wr;
        logic              out_load;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_ctl;

    typedef struct packed {
        logic ch_ok;
        logic out_free;
    } t_stat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic [CH_W-1:0]            channel;
    } t_in_payload;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       channel_valid;
    } t_out_payload;

    localparam t_ctl CTL_NOP = '{
        in_ready: 1'b0,
        acc_op:   ACC_HOLD,
        mul_sel:  MUL_NONE,
        load_w:   1'b0,
        mem_wr:   1'b0,
        out_load: 1'b0,
        jmp:      JMP_NONE,
        target:   STEP_WAIT
    };

    // microprogram: one control word per step
    function automatic t_ctl ucode(input logic [STEP_W-1:0] step);
        t_ctl c;
        c = CTL_NOP;
        case (step)
            4'd0: begin
                c.in_ready = 1'b1;
                c.jmp      = JMP_NO_INPUT;
                c.target   = STEP_WAIT;
            end
            4'd1: begin
                c.acc_op = ACC_LOAD_X;
                c.jmp    = JMP_BAD_CH;
                c.target = STEP_OUT;
            end
            4'd2: begin
                c.mul_sel = MUL_B1H1;
            end
            4'd3: begin
                c.mul_sel = MUL_B2H2;
                c.acc_op  = ACC_SUB;
            end
            4'd4: begin
                c.mul_sel = MUL_A1H1;
                c.acc_op  = ACC_SUB;
            end
            4'd5: begin
                // acc holds the feedback sum here, w is taken from it
                c.load_w  = 1'b1;
                c.acc_op  = ACC_LOAD_PROD;
                c.mul_sel = MUL_A2H2;
            end
            4'd6: begin
                c.acc_op  = ACC_ADD;
                c.mul_sel = MUL_A0W;
            end
            4'd7: begin
                c.acc_op = ACC_ADD;
                c.mem_wr = 1'b1;
            end
            4'd8: begin
                c.out_load = 1'b1;
                c.jmp      = JMP_OUT_BUSY;
                c.target   = STEP_OUT;
            end
            default: begin
                c = CTL_NOP;
            end
        endcase
        return c;
    endfunction

endpackage

@@ rtl/core/bqf_stream_if.sv @@
// valid/ready stream channel with a typed payload
`timescale 1ns / 1ps

interface bqf_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/core/bqf_seq.sv @@
// microcode sequencer: step counter, control rom and conditional jumps
`timescale 1ns / 1ps

module bqf_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  bqf_pkg::t_stat i_stat,
    output bqf_pkg::t_ctl  o_ctl
);

    logic [bqf_pkg::STEP_W-1:0] r_step;
    logic [bqf_pkg::STEP_W-1:0] n_step;
    bqf_pkg::t_ctl              w_ctl;
    logic                       w_jump;

    assign w_ctl = bqf_pkg::ucode(r_step);
    assign o_ctl = w_ctl;

    always_comb begin
        unique case (w_ctl.jmp)
            bqf_pkg::JMP_NONE:     w_jump = 1'b0;
            bqf_pkg::JMP_NO_INPUT: w_jump = !i_in_valid;
            bqf_pkg::JMP_BAD_CH:   w_jump = !i_stat.ch_ok;
            bqf_pkg::JMP_OUT_BUSY: w_jump = !i_stat.out_free;
            default:               w_jump = 1'b0;
        endcase
    end

    always_comb begin
        if (w_jump) begin
            n_step = w_ctl.target;
        end else if (r_step == bqf_pkg::STEP_LAST) begin
            n_step = bqf_pkg::STEP_WAIT;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= bqf_pkg::STEP_WAIT;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

@@ rtl/core/bqf_dp.sv @@
// datapath: coefficients, history memory, shared multiplier, accumulator, output register
`timescale 1ns / 1ps

module bqf_dp #(
    parameter int CHANNELS = bqf_pkg::CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bqf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bqf_pkg::COEF_W-1:0]          i_cfg_data,
    input  logic                                i_in_accept,
    input  logic signed [bqf_pkg::SAMPLE_W-1:0] i_sample_in,
    input  logic [bqf_pkg::CH_W-1:0]            i_channel,
    input  bqf_pkg::t_ctl                       i_ctl,
    output bqf_pkg::t_stat                      o_stat,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [bqf_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                o_channel_valid
);

    localparam int AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SAMP_W = bqf_pkg::SAMPLE_W;
    localparam int COEF_W = bqf_pkg::COEF_W;
    localparam int HIST_W = bqf_pkg::HIST_W;
    localparam int PROD_W = bqf_pkg::PROD_W;
    localparam int ACC_W  = bqf_pkg::ACC_W;
    localparam int FRAC   = bqf_pkg::FRAC;
    localparam int SH_W   = ACC_W - FRAC;
    localparam int CH_W   = bqf_pkg::CH_W;
    localparam logic [CH_W:0] CH_LIMIT = (CH_W + 1)'(CHANNELS);
    localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (FRAC - 1));

    // coefficients
    logic signed [COEF_W-1:0] r_ff0, r_ff1, r_ff2, r_fb1, r_fb2;
    logic                     w_cfg_hit;

    // latched transaction
    logic signed [SAMP_W-1:0] r_x;
    logic [AW-1:0]            r_ch;
    logic                     r_ch_ok;

    // history memory, {h1, h2} per channel, valid bit per entry
    logic [2*HIST_W-1:0]      mem [CHANNELS];
    logic [CHANNELS-1:0]      r_vld;
    logic [2*HIST_W-1:0]      r_rd_word;
    logic                     r_rd_hit;
    logic signed [HIST_W-1:0] w_h1, w_h2;

    // arithmetic
    logic signed [COEF_W-1:0] w_coef;
    logic signed [HIST_W-1:0] w_opnd;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  w_rnd_sum;
    logic signed [SH_W-1:0]   w_sh;
    logic signed [HIST_W-1:0] w_w_sat;
    logic signed [SAMP_W-1:0] w_y_sat;
    logic signed [HIST_W-1:0] r_w;

    // output register
    logic                     r_out_valid;
    logic signed [SAMP_W-1:0] r_out_sample;
    logic                     r_out_chv;
    logic                     w_out_free;

    assign w_out_free      = !r_out_valid || i_out_ready;
    assign o_stat.ch_ok    = r_ch_ok;
    assign o_stat.out_free = w_out_free;
    assign o_out_valid     = r_out_valid;
    assign o_sample_out    = r_out_sample;
    assign o_channel_valid = r_out_chv;

    always_comb begin
        unique case (i_cfg_idx)
            bqf_pkg::REG_FF0,
            bqf_pkg::REG_FF1,
            bqf_pkg::REG_FF2,
            bqf_pkg::REG_FB1,
            bqf_pkg::REG_FB2: w_cfg_hit = i_cfg_we;
            default:          w_cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff0 <= bqf_pkg::FF0_RESET;
            r_ff1 <= '0;
            r_ff2 <= '0;
            r_fb1 <= '0;
            r_fb2 <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bqf_pkg::REG_FF0: r_ff0 <= i_cfg_data;
                bqf_pkg::REG_FF1: r_ff1 <= i_cfg_data;
                bqf_pkg::REG_FF2: r_ff2 <= i_cfg_data;
                bqf_pkg::REG_FB1: r_fb1 <= i_cfg_data;
                bqf_pkg::REG_FB2: r_fb2 <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_x     <= i_sample_in;
            r_ch    <= i_channel[AW-1:0];
            r_ch_ok <= ({1'b0, i_channel} < CH_LIMIT);
        end
    end

    // history store: read on accept, write back {w, h1} once per item in range
    always_ff @(posedge i_clk) begin
        if (i_in_accept) begin
            r_rd_word <= mem[i_channel[AW-1:0]];
        end
        if (i_ctl.mem_wr) begin
            mem[r_ch] <= {r_w, w_h1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_in_accept) begin
                r_rd_hit <= r_vld[i_channel[AW-1:0]];
            end
            if (w_cfg_hit) begin
                r_vld <= '0;
            end else if (i_ctl.mem_wr) begin
                r_vld[r_ch] <= 1'b1;
            end
        end
    end

    // entry never written since the last clear reads as zero
    assign w_h1 = r_rd_hit ? r_rd_word[2*HIST_W-1:HIST_W] : '0;
    assign w_h2 = r_rd_hit ? r_rd_word[HIST_W-1:0] : '0;

    always_comb begin
        case (i_ctl.mul_sel)
            bqf_pkg::MUL_B1H1: begin
                w_coef = r_fb1;
                w_opnd = w_h1;
            end
            bqf_pkg::MUL_B2H2: begin
                w_coef = r_fb2;
                w_opnd = w_h2;
            end
            bqf_pkg::MUL_A1H1: begin
                w_coef = r_ff1;
                w_opnd = w_h1;
            end
            bqf_pkg::MUL_A2H2: begin
                w_coef = r_ff2;
                w_opnd = w_h2;
            end
            bqf_pkg::MUL_A0W: begin
                w_coef = r_ff0;
                w_opnd = r_w;
            end
            default: begin
                w_coef = r_ff0;
                w_opnd = r_w;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_sel != bqf_pkg::MUL_NONE) begin
            r_prod <= w_coef * w_opnd;
        end
    end

    always_comb begin
        case (i_ctl.acc_op)
            bqf_pkg::ACC_LOAD_X:
                n_acc = {{(ACC_W - SAMP_W - FRAC){r_x[SAMP_W-1]}}, r_x, {FRAC{1'b0}}};
            bqf_pkg::ACC_LOAD_PROD: n_acc = ACC_W'(r_prod);
            bqf_pkg::ACC_SUB:       n_acc = r_acc - ACC_W'(r_prod);
            bqf_pkg::ACC_ADD:       n_acc = r_acc + ACC_W'(r_prod);
            default:                n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    // round half up, floor by the fraction shift, then saturate
    assign w_rnd_sum = r_acc + RND_HALF;
    assign w_sh      = w_rnd_sum[ACC_W-1:FRAC];

    always_comb begin
        if ((&w_sh[SH_W-1:HIST_W-1]) || !(|w_sh[SH_W-1:HIST_W-1])) begin
            w_w_sat = w_sh[HIST_W-1:0];
        end else begin
            w_w_sat = {w_sh[SH_W-1], {(HIST_W - 1){~w_sh[SH_W-1]}}};
        end
        if ((&w_sh[SH_W-1:SAMP_W-1]) || !(|w_sh[SH_W-1:SAMP_W-1])) begin
            w_y_sat = w_sh[SAMP_W-1:0];
        end else begin
            w_y_sat = {w_sh[SH_W-1], {(SAMP_W - 1){~w_sh[SH_W-1]}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_w) begin
            r_w <= w_w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.out_load && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_load && w_out_free) begin
            r_out_sample <= r_ch_ok ? w_y_sat : '0;
            r_out_chv    <= r_ch_ok;
        end
    end

endmodule

@@ rtl/core/multichannel_biquad_filter_top.sv @@
// channel     | direction | payload
// i_in        | sink      | sample_in (s24 q0.23), channel (u4)
// o_out       | source    | sample_out (s24 q0.23), channel_valid (u1)
// cfg write   | sink      | i_cfg_we, i_cfg_idx (3b), i_cfg_data (24b), no read-back
//
// an item runs through the microcode steps from acceptance to a loaded result,
// with the single shared 24x32 multiplier doing five products; a channel out of range
// skips to the output step and loads its result there
// the next item is taken in the wait step after the load, never before the last is through
// a pending result in the output register does not block acceptance, only the final step
// reset is synchronous; history valid bits clear at once, no clearing pass
`timescale 1ns / 1ps
`include "multichannel_biquad_filter_top_defines.svh"

module multichannel_biquad_filter_top #(
    parameter int CHANNELS = bqf_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bqf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bqf_pkg::COEF_W-1:0]    i_cfg_data,
    bqf_stream_if.sink                    i_in,
    bqf_stream_if.source                  o_out
);

    bqf_pkg::t_ctl  w_ctl;
    bqf_pkg::t_stat w_stat;
    logic           w_in_accept;

    assign i_in.ready  = w_ctl.in_ready;
    assign w_in_accept = i_in.valid && w_ctl.in_ready;

    bqf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (w_stat),
        .o_ctl      (w_ctl)
    );

    bqf_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_accept     (w_in_accept),
        .i_sample_in     (i_in.payload.sample_in),
        .i_channel       (i_in.payload.channel),
        .i_ctl           (w_ctl),
        .o_stat          (w_stat),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_sample_out    (o_out.payload.sample_out),
        .o_channel_valid (o_out.payload.channel_valid)
    );

    // busy for the rest of the program once a transaction is taken
    `BQF_ASSERT_NEXT(a_busy_after_accept, w_in_accept, !i_in.ready)
    // a result for a channel out of range carries a zero sample
    `BQF_ASSERT_NOW(a_bad_ch_zero, o_out.valid && !o_out.payload.channel_valid, o_out.payload.sample_out == '0)
    // history is only written back for a channel in range
    `BQF_ASSERT_NOW(a_wr_only_ok, w_ctl.mem_wr, w_stat.ch_ok)

endmodule

@@ verif/bqf_filter_checker.sv @@
// predictor and result comparison for the multichannel biquad filter
`timescale 1ns / 1ps

module bqf_filter_checker #(
    parameter int CHANNELS = bqf_pkg::CHANNELS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bqf_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bqf_pkg::COEF_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  bqf_pkg::t_in_payload          i_in_payload,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  bqf_pkg::t_out_payload         i_out_payload,
    output int                            o_mismatches,
    output int                            o_pending
);

    localparam int     Q_SHIFT    = 20;
    localparam int     PRINT_MAX  = 100;
    localparam int     HIST_W     = bqf_pkg::HIST_W;
    localparam int     SAMPLE_W   = bqf_pkg::SAMPLE_W;
    localparam int     CFG_IDX_W  = bqf_pkg::CFG_IDX_W;
    localparam int     COEF_W     = bqf_pkg::COEF_W;
    localparam longint W_HI       = 64'sd2147483647;
    localparam longint W_LO       = -64'sd2147483648;
    localparam longint Y_HI       = 64'sd8388607;
    localparam longint Y_LO       = -64'sd8388608;

    longint gain_a0;
    longint gain_a1;
    longint gain_a2;
    longint gain_b1;
    longint gain_b2;

    logic signed [HIST_W-1:0] hist_one [CHANNELS];
    logic signed [HIST_W-1:0] hist_two [CHANNELS];

    bqf_pkg::t_out_payload predicted_samples [$];

    function automatic longint round_sat(input longint acc, input longint lo, input longint hi);
        longint r;
        // add half an lsb and floor, so ties go toward +inf
        r = (acc + (longint'(1) <<< (Q_SHIFT - 1))) >>> Q_SHIFT;
        if (r < lo) begin
            r = lo;
        end else if (r > hi) begin
            r = hi;
        end
        return r;
    endfunction

    function void clear_histories();
        for (int c = 0; c < CHANNELS; c++) begin
            hist_one[c] = '0;
            hist_two[c] = '0;
        end
    endfunction

    function void take_gain(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] data);
        longint v;
        v = longint'($signed(data));
        case (idx)
            bqf_pkg::REG_FF0: gain_a0 = v;
            bqf_pkg::REG_FF1: gain_a1 = v;
            bqf_pkg::REG_FF2: gain_a2 = v;
            bqf_pkg::REG_FB1: gain_b1 = v;
            bqf_pkg::REG_FB2: gain_b2 = v;
            default: return;
        endcase
        clear_histories();
    endfunction

    function bqf_pkg::t_out_payload filter_sample(input bqf_pkg::t_in_payload item);
        bqf_pkg::t_out_payload res;
        longint                x;
        longint                h1;
        longint                h2;
        longint                w;
        longint                y;
        res = '0;
        if (int'(item.channel) >= CHANNELS) begin
            return res;
        end
        x  = longint'($signed(item.sample_in));
        h1 = longint'(hist_one[item.channel]);
        h2 = longint'(hist_two[item.channel]);
        w  = x * (longint'(1) <<< Q_SHIFT) - gain_b1 * h1 - gain_b2 * h2;
        w  = round_sat(w, W_LO, W_HI);
        y  = gain_a0 * w + gain_a1 * h1 + gain_a2 * h2;
        y  = round_sat(y, Y_LO, Y_HI);
        hist_two[item.channel] = hist_one[item.channel];
        hist_one[item.channel] = w[HIST_W-1:0];
        res.sample_out    = y[SAMPLE_W-1:0];
        res.channel_valid = 1'b1;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (o_mismatches < PRINT_MAX) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        end
        o_mismatches++;
    endtask

    always @(posedge i_clk) begin
        bqf_pkg::t_out_payload want;
        if (!i_rst_n) begin
            gain_a0 = longint'(bqf_pkg::FF0_RESET);
            gain_a1 = 0;
            gain_a2 = 0;
            gain_b1 = 0;
            gain_b2 = 0;
            clear_histories();
            predicted_samples.delete();
        end else begin
            if (i_cfg_we) begin
                take_gain(i_cfg_idx, i_cfg_data);
            end
            if (i_out_valid && i_out_ready) begin
                if (predicted_samples.size() == 0) begin
                    report_mismatch("unexpected result", $signed(i_out_payload.sample_out), 0);
                end else begin
                    want = predicted_samples.pop_front();
                    if (i_out_payload.sample_out !== want.sample_out) begin
                        report_mismatch("sample_out", $signed(i_out_payload.sample_out),
                                        $signed(want.sample_out));
                    end
                    if (i_out_payload.channel_valid !== want.channel_valid) begin
                        report_mismatch("channel_valid", i_out_payload.channel_valid,
                                        want.channel_valid);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted_samples.push_back(filter_sample(i_in_payload));
            end
        end
        o_pending = predicted_samples.size();
    end

endmodule

@@ verif/multichannel_biquad_filter_top_tb.sv @@
// stimulus, clocking and verdict for the multichannel biquad filter
`timescale 1ns / 1ps

module multichannel_biquad_filter_top_tb;

    localparam int N_CH         = bqf_pkg::CHANNELS_DEF;
    localparam int SAMPLE_W     = bqf_pkg::SAMPLE_W;
    localparam int CH_W         = bqf_pkg::CH_W;
    localparam int COEF_W       = bqf_pkg::COEF_W;
    localparam int CFG_IDX_W    = bqf_pkg::CFG_IDX_W;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_HOLD   = 12;
    localparam int END_HOLD     = 30;
    localparam int RAND_PHASES  = 6;
    localparam int RANDOM_ITEMS = 1600;

    localparam logic signed [SAMPLE_W-1:0] VAL_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] VAL_MIN = 24'sh800000;
    localparam int                         Q_ONE   = 1048576;

    typedef enum logic [1:0] {
        STALL_NONE     = 2'd0,
        STALL_RANDOM   = 2'd1,
        STALL_PERIODIC = 2'd2,
        STALL_LONG     = 2'd3
    } t_stall;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [COEF_W-1:0]    cfg_data;

    int     mismatches;
    int     pending;
    int     burst_left;
    int     burst_max;
    int     gap_max;
    int     stall_run;
    int     stall_tick;
    int     idle_cycles;
    t_stall stall_style;

    bqf_stream_if #(.t_payload(bqf_pkg::t_in_payload))  in_ch ();
    bqf_stream_if #(.t_payload(bqf_pkg::t_out_payload)) out_ch ();

    multichannel_biquad_filter_top #(
        .CHANNELS(N_CH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    bqf_filter_checker #(
        .CHANNELS(N_CH)
    ) filter_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_idx     (cfg_idx),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_ch.valid),
        .i_in_ready    (in_ch.ready),
        .i_in_payload  (in_ch.payload),
        .i_out_valid   (out_ch.valid),
        .i_out_ready   (out_ch.ready),
        .i_out_payload (out_ch.payload),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // give up once no transaction has moved on either channel for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("[multichannel_biquad_filter_top] ERROR");
        $finish;
    end

    always @(negedge i_clk) begin
        case (stall_style)
            STALL_NONE: begin
                out_ch.ready = 1'b1;
            end
            STALL_RANDOM: begin
                out_ch.ready = ($urandom_range(0, 3) != 0);
            end
            STALL_PERIODIC: begin
                stall_tick   = (stall_tick + 1) % 7;
                out_ch.ready = (stall_tick >= 3);
            end
            default: begin
                if (stall_run == 0) begin
                    out_ch.ready = !out_ch.ready;
                    stall_run    = $urandom_range(1, 24);
                end else begin
                    stall_run--;
                end
            end
        endcase
    end

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] unit_gain();
        return COEF_W'(int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE);
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_item(input logic signed [SAMPLE_W-1:0] s, input logic [CH_W-1:0] ch);
        int gap;
        if (burst_left == 0) begin
            in_ch.valid = 1'b0;
            gap = $urandom_range(0, gap_max);
            repeat (gap) @(negedge i_clk);
            burst_left = $urandom_range(1, burst_max);
        end
        in_ch.valid             = 1'b1;
        in_ch.payload.sample_in = s;
        in_ch.payload.channel   = ch;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        @(negedge i_clk);
        burst_left--;
    endtask

    task automatic drain();
        in_ch.valid = 1'b0;
        burst_left  = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_HOLD) @(negedge i_clk);
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    task automatic set_gains(input logic [COEF_W-1:0] a0, input logic [COEF_W-1:0] a1,
                             input logic [COEF_W-1:0] a2, input logic [COEF_W-1:0] b1,
                             input logic [COEF_W-1:0] b2);
        write_coef(bqf_pkg::REG_FF0, a0);
        write_coef(bqf_pkg::REG_FF1, a1);
        write_coef(bqf_pkg::REG_FF2, a2);
        write_coef(bqf_pkg::REG_FB1, b1);
        write_coef(bqf_pkg::REG_FB2, b2);
    endtask

    initial begin
        logic [CH_W-1:0] focus_ch;
        logic [CH_W-1:0] ch;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        stall_style   = STALL_NONE;
        burst_left    = 0;
        burst_max     = 8;
        gap_max       = 4;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset gains pass every sample straight through
        send_item(VAL_MAX, CH_W'(0));
        send_item(VAL_MIN, CH_W'(0));
        send_item(SAMPLE_W'(0), CH_W'(N_CH - 1));
        send_item(SAMPLE_W'(-1), CH_W'(N_CH - 1));
        send_item(SAMPLE_W'(1), CH_W'(5));
        send_item(24'sh555555, CH_W'(10));
        send_item(24'shAAAAAA, CH_W'(3));
        drain();

        // extreme gains push output and history into saturation
        set_gains(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, VAL_MAX);
        send_item(VAL_MAX, CH_W'(1));
        send_item(VAL_MAX, CH_W'(1));
        send_item(VAL_MIN, CH_W'(1));
        send_item(VAL_MAX, CH_W'(1));
        send_item(SAMPLE_W'(0), CH_W'(2));
        send_item(VAL_MIN, CH_W'(2));
        drain();
        set_gains(VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN, VAL_MIN);
        send_item(VAL_MAX, CH_W'(4));
        send_item(VAL_MAX, CH_W'(4));
        send_item(VAL_MAX, CH_W'(4));
        send_item(VAL_MIN, CH_W'(4));
        drain();

        // a write past the last register leaves the history alone
        write_coef(CFG_IDX_W'(bqf_pkg::REG_FB2 + 1), COEF_W'(Q_ONE));
        send_item(VAL_MAX, CH_W'(4));
        send_item(VAL_MIN, CH_W'(4));
        drain();

        // rewriting a gain with its current value still clears every history
        write_coef(bqf_pkg::REG_FF1, VAL_MIN);
        send_item(VAL_MAX, CH_W'(4));
        send_item(SAMPLE_W'(1), CH_W'(4));
        drain();

        for (int k = 0; k < RAND_PHASES; k++) begin
            stall_style = t_stall'(k % 4);
            burst_max   = (k == 2) ? 60 : $urandom_range(1, 12);
            gap_max     = (k == 2) ? 0 : $urandom_range(2, 30);
            focus_ch    = CH_W'($urandom_range(0, N_CH - 1));
            case (k)
                // lowpass, double pole
                0: set_gains(COEF_W'(20972), COEF_W'(41943), COEF_W'(20972),
                             COEF_W'(-1677722), COEF_W'(671089));
                // near-resonant
                1: set_gains(COEF_W'(Q_ONE), COEF_W'(-Q_ONE), COEF_W'(Q_ONE / 2),
                             COEF_W'(-1992294), COEF_W'(996147));
                3: set_gains(unit_gain(), unit_gain(), unit_gain(), unit_gain(), unit_gain());
                4: set_gains(unit_gain(), unit_gain(), unit_gain(), '0, '0); // feed-forward only
                default: set_gains(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                                   COEF_W'($urandom), COEF_W'($urandom));
            endcase
            for (int n = 0; n < RANDOM_ITEMS / RAND_PHASES; n++) begin
                if ($urandom_range(0, 99) == 0) begin
                    drain();
                    write_coef(CFG_IDX_W'($urandom), COEF_W'($urandom));
                end
                if ($urandom_range(0, 3) == 0) begin
                    ch = focus_ch;
                end else begin
                    ch = CH_W'($urandom_range(0, N_CH - 1));
                end
                send_item(rand_sample(), ch);
            end
            drain();
        end

        repeat (END_HOLD) @(negedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("[multichannel_biquad_filter_top] OK");
        end else begin
            $display("[multichannel_biquad_filter_top] ERROR");
        end
        $finish;
    end

endmodule
